// ===== hw/rtl/perceptron_train_and_classify_unit_macros.svh =====
// assertion macros for the perceptron classifier block
`ifndef PERCEPTRON_TRAIN_AND_CLASSIFY_UNIT_MACROS_SVH
`define PERCEPTRON_TRAIN_AND_CLASSIFY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTC_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, disabled during reset
`define PTC_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/ptc_pkg.sv =====
// shared types, constants and helpers for the perceptron classifier
package ptc_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int IDX_W        = $clog2(MAX_FEATURES + 1);
  localparam int BUF_W        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FEAT_W       = 16;
  localparam int W_W          = 32;
  localparam int ACC_W        = 56;
  localparam int PROD_W       = FEAT_W + W_W;
  localparam int RATE_W       = 16;
  localparam int FC_W         = 5;
  localparam int KIND_W       = 2;
  localparam int WIDX_W       = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  // feature operand is one sign bit wider so that its negation fits
  localparam int XOP_W        = FEAT_W + 1;
  localparam int R2_W         = RATE_W + 2;
  localparam int UPROD_W      = XOP_W + R2_W;
  localparam int STEP_W       = UPROD_W - 8;

  // 1.0 in Q8.8, used as the bias input so the bias step is exactly 2*rate
  localparam logic signed [XOP_W-1:0] FEATURE_ONE = XOP_W'(256);
  localparam logic signed [W_W-1:0]   W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0]   W_MIN = {1'b1, {(W_W-1){1'b0}}};

  localparam logic [FC_W-1:0]   FC_RESET   = FC_W'(2);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(655);

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRAIN = 2'd1,
    KIND_INFER = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_COUNT = 1'b0,
    CFG_LEARNING_RATE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_BIAS,
    ST_SCORE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [FEAT_W-1:0] feature_value;
    logic                     last_feature;
    logic                     label_positive;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [W_W-1:0]    weight_value;
  } in_item_t;

  typedef struct packed {
    logic signed [W_W-1:0] score;
    logic                  predicted_positive;
    logic                  weights_updated;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

  typedef struct packed {
    logic             go;
    logic [IDX_W-1:0] idx;
  } upd_req_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    logic signed [W_W-1:0] data;
    logic                  changed;
  } upd_wr_t;

  function automatic logic [IDX_W-1:0] eff_count(input logic [FC_W-1:0] fc);
    if (int'(fc) > MAX_FEATURES) begin
      return IDX_W'(MAX_FEATURES);
    end
    return IDX_W'(fc);
  endfunction

  function automatic logic widx_ok(input logic [WIDX_W-1:0] widx);
    return int'(widx) <= MAX_FEATURES;
  endfunction

endpackage

// ===== hw/rtl/ptc_ram.sv =====
// generic single write, single read ram with registered read data
module ptc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ptc_mac.sv =====
// feature by weight multiply, registered, then accumulate
module ptc_mac import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [FEAT_W-1:0] x,
  input  logic signed [W_W-1:0]    w,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pend_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= x * w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      pend_r <= ctl.mul_en;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (pend_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/ptc_update.sv =====
// two-stage weight update pipe: step multiply, then saturating add
module ptc_update import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  upd_req_t                 req,
  input  logic signed [W_W-1:0]    w,
  input  logic signed [FEAT_W-1:0] x,
  input  logic [RATE_W-1:0]        rate,
  input  logic                     label_pos,
  output upd_wr_t                  wr
);

  logic signed [XOP_W-1:0]   xs;
  logic signed [XOP_W-1:0]   xop;
  logic signed [R2_W-1:0]    rate2;
  logic signed [UPROD_W-1:0] prod;
  logic signed [STEP_W-1:0]  step_r;
  logic signed [W_W-1:0]     w2_r;
  logic [IDX_W-1:0]          idx2_r;
  logic                      go2_r;
  logic signed [W_W:0]       sum;
  logic signed [W_W-1:0]     new_w;

  // bias uses a feature of one
  assign xs    = (req.idx == '0) ? FEATURE_ONE : XOP_W'(x);
  assign xop   = label_pos ? xs : -xs;
  assign rate2 = $signed({1'b0, rate, 1'b0});
  assign prod  = rate2 * xop;

  always_ff @(posedge clk) begin
    step_r <= prod[UPROD_W-1:8];
    w2_r   <= w;
    idx2_r <= req.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go2_r <= 1'b0;
    end else begin
      go2_r <= req.go;
    end
  end

  assign sum = (W_W+1)'(w2_r) + (W_W+1)'(step_r);

  always_comb begin
    if (sum[W_W] != sum[W_W-1]) begin
      new_w = sum[W_W] ? W_MIN : W_MAX;
    end else begin
      new_w = sum[W_W-1:0];
    end
  end

  assign wr.en      = go2_r;
  assign wr.addr    = idx2_r;
  assign wr.data    = new_w;
  assign wr.changed = new_w != w2_r;

endmodule

// ===== hw/rtl/perceptron_train_and_classify_unit.sv =====
// top level of the fixed-point perceptron classifier with training
//
// input channel (in_valid/in_ready/in_data) carries one request per
// weight write or sample feature; in_ready is high only while the
// sequencer is idle. a feature request within the count first reads
// its weight from the weight ram, then does the registered 16x32
// multiply; the product is added while the next request is taken. on a
// last feature a bias read and a score and saturation step come before
// the output load; a misclassified training request walks weights 0..p
// (p = features taken) through the two-stage update pipe, one per cycle,
// and drains it before the result load.
// result channel (out_valid/out_ready/out_data) has an output register;
// weight writes and non-last features are still taken while a result
// waits, and the sequencer holds the next result until out_ready frees
// the register. config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is
// always ready. reset clears the weight valid bits so every weight reads
// zero, with no clearing pass; config returns to 2 features, rate 655.
`include "perceptron_train_and_classify_unit_macros.svh"

module perceptron_train_and_classify_unit import ptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_e state_r, state_nxt;

  // config registers
  logic [FC_W-1:0]   fc_r;
  logic [RATE_W-1:0] rate_r;

  // current request and sample bookkeeping
  in_item_t         item_r;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] u_r, u_nxt;
  logic             drain_r;
  logic [IDX_W-1:0] n_eff;

  // weight ram with per-entry valid bits (unwritten entries read zero)
  logic [MAX_FEATURES:0] wvalid_r;
  logic                  rvalid_r;
  logic                  w_we;
  logic                  w_we_host;
  logic [IDX_W-1:0]      w_waddr;
  logic [W_W-1:0]        w_wdata;
  logic [IDX_W-1:0]      w_raddr;
  logic [W_W-1:0]        w_rdata;
  logic signed [W_W-1:0] w_rd;

  // sample buffer ram
  logic                  sb_we;
  logic [IDX_W-1:0]      u_dec;
  logic [BUF_W-1:0]      sb_raddr;
  logic [FEAT_W-1:0]     sb_rdata;

  // datapath
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc;
  upd_req_t                wreq_r;
  upd_wr_t                 upd_wr;

  // score path
  logic signed [ACC_W:0]  total;
  logic signed [W_W-1:0]  score_c;
  logic                   pred_c;
  logic                   mis_c;
  logic                   load_score;
  logic signed [W_W-1:0]  score_r;
  logic                   pred_r;
  logic                   changed_r;

  // output register
  logic      out_load;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign n_eff     = eff_count(fc_r);
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= FC_RESET;
      rate_r <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FEATURE_COUNT: fc_r   <= cfg_data[FC_W-1:0];
        CFG_LEARNING_RATE: rate_r <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    u_nxt      = u_r;
    in_ready   = 1'b0;
    w_we_host  = 1'b0;
    w_raddr    = '0;
    sb_we      = 1'b0;
    mac_ctl    = '0;
    load_score = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.kind)
            KIND_WRITE: begin
              w_we_host = widx_ok(in_data.weight_index);
            end
            KIND_TRAIN, KIND_INFER: begin
              if (pos_r < n_eff) begin
                // buffer the feature and fetch its weight
                sb_we     = 1'b1;
                w_raddr   = pos_r + 1'b1;
                pos_nxt   = pos_r + 1'b1;
                state_nxt = ST_MUL;
              end else if (in_data.last_feature) begin
                state_nxt = ST_BIAS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt = item_r.last_feature ? ST_BIAS : ST_IDLE;
      end
      ST_BIAS: begin
        w_raddr   = '0;
        state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        load_score = 1'b1;
        if (mis_c) begin
          u_nxt     = '0;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_WALK: begin
        // bias first, then each weight that saw a feature
        w_raddr = u_r;
        if (u_r == pos_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          u_nxt = u_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          mac_ctl.clear = 1'b1;
          pos_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      u_r     <= '0;
      drain_r <= 1'b0;
      wreq_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      u_r        <= u_nxt;
      drain_r    <= (state_r == ST_DRAIN) ? ~drain_r : 1'b0;
      wreq_r.go  <= state_r == ST_WALK;
      wreq_r.idx <= u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // weight ram port muxing; the update pipe owns the write port in the walk
  assign w_we    = upd_wr.en | w_we_host;
  assign w_waddr = upd_wr.en ? upd_wr.addr : IDX_W'(in_data.weight_index);
  assign w_wdata = upd_wr.en ? upd_wr.data : in_data.weight_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (w_we) begin
        wvalid_r[w_waddr] <= 1'b1;
      end
      rvalid_r <= wvalid_r[w_raddr];
    end
  end

  assign w_rd = rvalid_r ? $signed(w_rdata) : '0;

  ptc_ram #(
    .WIDTH (W_W),
    .DEPTH (MAX_FEATURES + 1),
    .AW    (IDX_W)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // feature of weight u sits at buffer entry u-1
  assign u_dec    = u_r - 1'b1;
  assign sb_raddr = u_dec[BUF_W-1:0];

  ptc_ram #(
    .WIDTH (FEAT_W),
    .DEPTH (MAX_FEATURES),
    .AW    (BUF_W)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sb_we),
    .waddr (pos_r[BUF_W-1:0]),
    .wdata (in_data.feature_value),
    .raddr (sb_raddr),
    .rdata (sb_rdata)
  );

  ptc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (item_r.feature_value),
    .w     (w_rd),
    .acc   (acc)
  );

  ptc_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (wreq_r),
    .w         (w_rd),
    .x         ($signed(sb_rdata)),
    .rate      (rate_r),
    .label_pos (item_r.label_positive),
    .wr        (upd_wr)
  );

  // score = floor((acc + bias*256) / 256), saturated to 32 bits
  assign total = (ACC_W+1)'(acc) + (ACC_W+1)'($signed({w_rd, 8'h00}));

  always_comb begin
    if ((&total[ACC_W:W_W+7]) || !(|total[ACC_W:W_W+7])) begin
      score_c = total[W_W+7:8];
    end else begin
      score_c = total[ACC_W] ? W_MIN : W_MAX;
    end
  end

  assign pred_c = !score_c[W_W-1];
  assign mis_c  = (item_r.kind == KIND_TRAIN) && (pred_c != item_r.label_positive);

  always_ff @(posedge clk) begin
    if (load_score) begin
      score_r <= score_c;
      pred_r  <= pred_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
    end else if (load_score) begin
      changed_r <= 1'b0;
    end else if (upd_wr.en && upd_wr.changed) begin
      changed_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.score              <= score_r;
      out_data_r.predicted_positive <= pred_r;
      out_data_r.weights_updated    <= changed_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // update pipe writes land only during the walk or its drain
  `PTC_ASSERT_IMP(a_walk_write_window, upd_wr.en, (state_r == ST_WALK) || (state_r == ST_DRAIN), "update write outside training walk")
  // walk index never passes the features taken
  `PTC_ASSERT_IMP(a_walk_bound, state_r == ST_WALK, u_r <= pos_r, "walk index beyond sample")
  // loading a result shows it and rearms the sample
  `PTC_ASSERT_NXT(a_result_rearm, (state_r == ST_RESULT) && (!out_valid_r || out_ready), out_valid && (pos_r == '0) && (state_r == ST_IDLE), "result load did not rearm sample")

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the perceptron classifier: directed table, then random phases
module tb;
  import ptc_pkg::*;

  // the request kind that the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 30;
  localparam int HOLD_CYCLES   = 240;  // long receiver hold-off, fills the block
  localparam int STALL_LIMIT   = 3000; // cycles with no handshake before giving up
  localparam int REPORT_MAX    = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the block state and registers
  int              weight_mem [0:MAX_FEATURES];
  shortint         feature_hold [0:MAX_FEATURES-1];
  longint          mac_sum;
  int              taken;
  logic [FC_W-1:0]   feat_count_cfg;
  logic [RATE_W-1:0] rate_cfg;

  out_item_t expected_scores [$];

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  directed_row_t directed_rows [$];

  bit idle_enable  = 1'b1;
  bit hold_pending = 1'b0;

  int requests_sent    = 0;
  int scores_checked   = 0;
  int updates_seen     = 0;
  int settings_applied = 0;
  int mismatch_count   = 0;

  perceptron_train_and_classify_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp32(input longint v);
    if (v > longint'(W_MAX)) return int'(W_MAX);
    if (v < longint'(W_MIN)) return int'(W_MIN);
    return int'(v);
  endfunction

  // score, class and training update for one accepted request
  function automatic void predict_request(input in_item_t req, output bit has_score,
                                          output out_item_t score_item);
    int     lim;
    int     i;
    int     moved;
    int     score;
    longint total;
    longint rate2;
    longint step;
    bit     pred;
    bit     changed;
    has_score  = 1'b0;
    score_item = '0;
    changed    = 1'b0;
    case (req.kind)
      KIND_WRITE: begin
        // indexes past the last feature weight are dropped
        if (int'(req.weight_index) <= MAX_FEATURES) begin
          weight_mem[req.weight_index] = int'(req.weight_value);
        end
      end
      KIND_TRAIN, KIND_INFER: begin
        lim = int'(feat_count_cfg);
        if (lim > MAX_FEATURES) lim = MAX_FEATURES;
        // features past the count are ignored
        if (taken < lim) begin
          feature_hold[taken] = shortint'(req.feature_value);
          mac_sum += longint'(shortint'(req.feature_value)) * longint'(weight_mem[taken + 1]);
          taken++;
        end
        if (req.last_feature) begin
          // q24.24 sum plus bias, floored back to q16.16
          total = mac_sum + longint'(weight_mem[0]) * 256;
          score = clamp32(total >>> 8);
          pred  = (score >= 0);
          if (req.kind == KIND_TRAIN && pred != req.label_positive) begin
            rate2 = 2 * longint'(rate_cfg);
            moved = clamp32(longint'(weight_mem[0]) + (req.label_positive ? rate2 : -rate2));
            if (moved != weight_mem[0]) changed = 1'b1;
            weight_mem[0] = moved;
            // only features taken in this sample move their weights
            for (i = 0; i < taken; i++) begin
              step = rate2 * longint'(feature_hold[i]);
              if (!req.label_positive) step = -step;
              moved = clamp32(longint'(weight_mem[i + 1]) + (step >>> 8));
              if (moved != weight_mem[i + 1]) changed = 1'b1;
              weight_mem[i + 1] = moved;
            end
          end
          mac_sum = 0;
          taken   = 0;
          has_score = 1'b1;
          score_item.score              = score;
          score_item.predicted_positive = pred;
          score_item.weights_updated    = changed;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [FEAT_W-1:0] feat,
                                  input bit last, input bit label,
                                  input logic [WIDX_W-1:0] widx, input logic [W_W-1:0] wval,
                                  input bit typed, input logic [W_W-1:0] score,
                                  input bit pred, input bit upd);
    directed_row_t row;
    row.req.kind                  = kind;
    row.req.feature_value         = feat;
    row.req.last_feature          = last;
    row.req.label_positive        = label;
    row.req.weight_index          = widx;
    row.req.weight_value          = wval;
    row.typed                     = typed;
    row.want.score                = score;
    row.want.predicted_positive   = pred;
    row.want.weights_updated      = upd;
    directed_rows.push_back(row);
  endfunction

  function automatic in_item_t junk_request();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // mostly small values near the origin, sometimes the full range
  function automatic logic [FEAT_W-1:0] pick_feature();
    if ($urandom_range(0, 3) == 0) return FEAT_W'($urandom());
    return FEAT_W'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic logic [W_W-1:0] pick_weight();
    if ($urandom_range(0, 4) == 0) return W_W'($urandom());
    return W_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic in_item_t weight_write_request();
    in_item_t req;
    req = junk_request();
    req.kind = KIND_WRITE;
    if ($urandom_range(0, 7) == 0) begin
      req.weight_index = WIDX_W'($urandom_range(MAX_FEATURES + 1, (1 << WIDX_W) - 1));
    end else begin
      req.weight_index = WIDX_W'($urandom_range(0, MAX_FEATURES));
    end
    req.weight_value = pick_weight();
    return req;
  endfunction

  task automatic send_request(input in_item_t req, input bit typed, input out_item_t typed_score);
    bit        has_score;
    out_item_t predicted;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req, has_score, predicted);
    if (has_score) expected_scores.push_back(typed ? typed_score : predicted);
    requests_sent++;
  endtask

  // leaves cfg_valid high so back-to-back writes keep it asserted
  task automatic write_register(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      CFG_FEATURE_COUNT: feat_count_cfg = value[FC_W-1:0];
      CFG_LEARNING_RATE: rate_cfg = value;
      default: begin
      end
    endcase
    settings_applied++;
  endtask

  task automatic configure(input logic [FC_W-1:0] count, input logic [RATE_W-1:0] rate);
    // upper data bits are don't-care for the count register
    write_register(CFG_FEATURE_COUNT, CFG_DATA_W'({$urandom(), count}));
    write_register(CFG_LEARNING_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every score is back and the last feature has cleared
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // whole samples with random content, plus weight writes and ignored kinds
  task automatic random_phase(input int target);
    in_item_t req;
    int       done;
    int       roll;
    int       span;
    int       len;
    int       i;
    bit       train;
    done = 0;
    while (done < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_request(weight_write_request(), 1'b0, '0);
        done++;
      end else if (roll < 11) begin
        req = junk_request();
        req.kind = KIND_UNUSED;
        send_request(req, 1'b0, '0);
      end else begin
        span = int'(feat_count_cfg);
        if (span > MAX_FEATURES) span = MAX_FEATURES;
        case ($urandom_range(0, 9))
          0: len = (span > 1) ? span - 1 : 1;                // short sample
          1: len = span + int'($urandom_range(1, 2));        // extra features
          default: len = (span > 0) ? span : 1;
        endcase
        train = ($urandom_range(0, 9) < 7);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_request(weight_write_request(), 1'b0, '0);
            done++;
          end
          req = junk_request();
          req.kind = train ? KIND_TRAIN : KIND_INFER;
          // a stray kind mid-sample, the last one decides
          if (i < len - 1 && $urandom_range(0, 9) == 0) begin
            req.kind = train ? KIND_INFER : KIND_TRAIN;
          end
          req.feature_value = pick_feature();
          req.last_feature  = (i == len - 1);
          send_request(req, 1'b0, '0);
          done++;
        end
      end
    end
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        // long hold-off while the sender keeps offering requests
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("tb: %s: expected score %h class %0d update %0d, got score %h class %0d update %0d",
               what, want.score, want.predicted_positive, want.weights_updated,
               got.score, got.predicted_positive, got.weights_updated);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      scores_checked++;
      if (out_data.weights_updated) updates_seen++;
      if (expected_scores.size() == 0) begin
        note_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = expected_scores.pop_front();
        if (out_data.score !== want.score ||
            out_data.predicted_positive !== want.predicted_positive ||
            out_data.weights_updated !== want.weights_updated) begin
          note_mismatch("score mismatch", want, out_data);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k <= MAX_FEATURES; k++) weight_mem[k] = 0;
    mac_sum        = 0;
    taken          = 0;
    feat_count_cfg = FC_RESET;
    rate_cfg       = RATE_RESET;

    // reset settings: two features, rate 655, all weights zero
    add_row(KIND_INFER, 16'h7fff, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // zero score counts as the positive class
    add_row(KIND_INFER, 16'h8000, 1'b1, 1'b0, '0, '0, 1'b1, 32'h0, 1'b1, 1'b0);
    add_row(KIND_TRAIN, 16'h0100, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // misclassified negative sample moves every weight
    add_row(KIND_TRAIN, 16'hff00, 1'b1, 1'b0, '0, '0, 1'b1, 32'h0, 1'b1, 1'b1);
    add_row(KIND_INFER, 16'h0100, 1'b1, 1'b1, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // unused kind, ignored even with last set
    add_row(KIND_UNUSED, 16'h1234, 1'b1, 1'b1, 5'd3, 32'h1, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd0, 32'h7fffffff, 1'b0, '0, 1'b0, 1'b0);
    // out-of-range weight indexes
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd17, 32'h12345678, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd31, 32'h0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd1, 32'h80000000, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd2, 32'h7fffffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h7fff, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h7fff, 1'b1, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd0, 32'h80000000, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h8000, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // weight write mid-sample, then a sum that saturates high
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd2, 32'h80000000, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h8000, 1'b1, 1'b0, '0, '0, 1'b1, 32'h7fffffff, 1'b1, 1'b0);
    // three features with a count of two
    add_row(KIND_INFER, 16'h0100, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h0100, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h0100, 1'b1, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // short training sample, second weight stays put
    add_row(KIND_TRAIN, 16'h7fff, 1'b1, 1'b1, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // training feature closed by an inference last feature
    add_row(KIND_TRAIN, 16'h8000, 1'b0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_INFER, 16'h0100, 1'b1, 1'b1, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    // bias pinned at the top while the score saturates low
    add_row(KIND_WRITE, '0, 1'b0, 1'b0, 5'd0, 32'h7fffffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(KIND_TRAIN, 16'h7fff, 1'b1, 1'b1, '0, '0, 1'b1, 32'h80000000, 1'b0, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < directed_rows.size(); k++) begin
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    end
    random_phase(220);
    settle();

    // rate zero: misclassified samples leave the weights unchanged
    configure(5'd1, 16'd0);
    random_phase(170);
    settle();

    configure(5'd16, 16'hffff);
    random_phase(280);
    settle();

    // count zero: score is the bias alone
    configure(5'd0, 16'd1);
    random_phase(100);
    settle();

    // count above the maximum acts as the maximum
    configure(5'd31, 16'd300);
    random_phase(170);
    settle();

    configure(FC_W'($urandom_range(3, 8)), RATE_W'($urandom()));
    hold_pending = 1'b1;
    random_phase(280);
    settle();

    // closing stretch runs without idling on either side
    configure(5'd2, RATE_RESET);
    idle_enable = 1'b0;
    random_phase(380);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests driven across %0d register writes", requests_sent,
             settings_applied);
    $display("tb: %0d scores checked, %0d with weight updates, %0d mismatches",
             scores_checked, updates_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
